// File: rtl/drive_joystick_mixer_core_macros.svh
// assertion macros for the drive joystick mixer
`ifndef DRIVE_JOYSTICK_MIXER_CORE_MACROS_SVH
`define DRIVE_JOYSTICK_MIXER_CORE_MACROS_SVH

`ifndef SYNTH
`define DJM_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DJM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DJM_ASSERT_HOLDS(label, ante, cons)
`define DJM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/djm_pkg.sv
// shared types, constants and sine table for the drive joystick mixer
`timescale 1ns / 1ps

package djm_pkg;

  localparam int SINE_DEPTH = 256;
  localparam int IDX_W = $clog2(SINE_DEPTH + 1);

  localparam logic [16:0] Q15_ONE = 17'd32768;
  localparam logic [16:0] Q15_HALF = 17'd16384;
  localparam logic [16:0] DEADBAND_MAG = 17'd32;
  localparam logic [15:0] GAIN_BASE = 16'd22938;
  localparam logic [15:0] GAIN_SLOPE = 16'd42598;
  localparam logic [15:0] PREC_GAIN = 16'd26214;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    CURVE_NONE,
    CURVE_LINEAR,
    CURVE_EASE_IN,
    CURVE_EASE_OUT,
    CURVE_EASE_IN_OUT,
    CURVE_SINE
  } curve_t;

  typedef enum logic [1:0] {
    REG_MIX_MODE,
    REG_CURVE_SELECT,
    REG_PRECISION_ON,
    REG_DRIVE_ENABLE
  } reg_idx_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } adv_t;

  typedef logic [16:0] sine_rom_t [0:SINE_DEPTH];

  function automatic sine_rom_t sine_rom_build();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    int k;
    int n;
    for (k = 0; k <= SINE_DEPTH; k++) begin
      x = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      r = (sum + 64'd16384) >> 15;
      rom[k] = (r > 64'(Q15_ONE)) ? Q15_ONE : r[16:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_build();

endpackage

// File: rtl/djm_curve.sv
// response curve pipeline for one stick axis: magnitude, square, shaped value
`timescale 1ns / 1ps

module djm_curve
  import djm_pkg::*;
(
  input  logic              clk,
  input  adv_t              adv,
  input  logic [2:0]        curve_select,
  input  logic [15:0]       raw,
  output logic [16:0]       shaped_mag,
  output logic              shaped_neg
);

  logic [16:0]      m1;
  logic             neg1;
  logic [16:0]      m2;
  logic             neg2;
  logic [29:0]      sq2;
  logic [IDX_W-1:0] idx2;

  logic [16:0] u1;
  logic        use_u1;
  logic [14:0] opnd1;
  logic [31:0] idx_full1;
  logic [16:0] r15;
  logic [16:0] r14;
  logic        pass2;
  logic [16:0] e2;

  // stage 1: magnitude
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      neg1 <= raw[15];
      m1 <= raw[15] ? (17'd0 - {raw[15], raw}) : {1'b0, raw};
    end
  end

  // stage 2: square and sine index
  always_comb begin
    u1 = Q15_ONE - m1;
    use_u1 = (curve_select == CURVE_EASE_OUT) ||
             ((curve_select == CURVE_EASE_IN_OUT) && (m1 >= Q15_HALF));
    opnd1 = use_u1 ? u1[14:0] : m1[14:0];
    idx_full1 = ({15'd0, m1} * 32'(SINE_DEPTH) + 32'd16384) >> 15;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      m2 <= m1;
      neg2 <= neg1;
      sq2 <= 30'(opnd1) * 30'(opnd1);
      idx2 <= idx_full1[IDX_W-1:0];
    end
  end

  // stage 3: shaped magnitude
  always_comb begin
    r15 = 17'((31'(sq2) + 31'd16384) >> 15);
    r14 = 17'((31'(sq2) + 31'd8192) >> 14);
    pass2 = (curve_select == CURVE_NONE) || (m2 <= DEADBAND_MAG) || (m2 >= Q15_ONE);
    case (curve_select)
      CURVE_LINEAR:      e2 = m2;
      CURVE_EASE_IN:     e2 = r15;
      CURVE_EASE_OUT:    e2 = Q15_ONE - r15;
      CURVE_EASE_IN_OUT: e2 = (m2 < Q15_HALF) ? r14 : (Q15_ONE - r14);
      default:           e2 = SINE_ROM[idx2];
    endcase
    if (pass2) begin
      e2 = m2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      shaped_mag <= e2;
      shaped_neg <= neg2;
    end
  end

endmodule

// File: rtl/djm_gain.sv
// gain pipeline: pot to gain, precision scaling
`timescale 1ns / 1ps

module djm_gain
  import djm_pkg::*;
(
  input  logic        clk,
  input  adv_t        adv,
  input  logic        precision_on,
  input  logic [15:0] pot_level,
  output logic [16:0] gain
);

  logic [31:0] gp1;
  logic [16:0] g2;
  logic [33:0] pg2;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      gp1 <= 32'(GAIN_SLOPE) * {16'd0, pot_level};
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      g2 <= 17'(GAIN_BASE) + 17'((33'(gp1) + 33'd32768) >> 16);
    end
  end

  assign pg2 = 34'(g2) * 34'(PREC_GAIN) + 34'd32768;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      gain <= precision_on ? 17'(pg2 >> 16) : g2;
    end
  end

endmodule

// File: rtl/djm_mix.sv
// scaling, tank or differential mixing, motor conversion
`timescale 1ns / 1ps

module djm_mix
  import djm_pkg::*;
(
  input  logic        clk,
  input  adv_t        adv,
  input  logic        mix_mode,
  input  logic        drive_enable,
  input  logic [16:0] mag_a,
  input  logic        neg_a,
  input  logic [16:0] mag_b,
  input  logic        neg_b,
  input  logic [16:0] gain,
  output logic [15:0] left_drive,
  output logic [15:0] right_drive
);

  logic [33:0]        p_a;
  logic [33:0]        p_b;
  logic [16:0]        v_a;
  logic [16:0]        v_b;
  logic signed [17:0] s_a;
  logic signed [17:0] s_b;
  logic signed [18:0] left_sum;
  logic signed [18:0] right_sum;

  function automatic logic [15:0] to_motor(input logic signed [18:0] s);
    logic [18:0] mag;
    logic [15:0] r;
    mag = s[18] ? (19'd0 - s) : s;
    if (mag > 19'(Q15_ONE)) begin
      mag = 19'(Q15_ONE);
    end
    r = (mag == 19'd0) ? 16'd0 : 16'(mag - 19'd1);
    return s[18] ? (16'd0 - r) : r;
  endfunction

  // stage 4: scale by gain
  always_comb begin
    p_a = 34'(mag_a) * 34'(gain) + 34'd32768;
    p_b = 34'(mag_b) * 34'(gain) + 34'd32768;
    v_a = 17'(p_a >> 16);
    v_b = 17'(p_b >> 16);
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      s_a <= neg_a ? (18'd0 - {1'b0, v_a}) : {1'b0, v_a};
      s_b <= neg_b ? (18'd0 - {1'b0, v_b}) : {1'b0, v_b};
    end
  end

  // stage 5: mix and convert
  always_comb begin
    if (mix_mode) begin
      left_sum = {s_a[17], s_a} + {s_b[17], s_b};
      right_sum = {s_a[17], s_a} - {s_b[17], s_b};
    end else begin
      left_sum = {s_a[17], s_a};
      right_sum = {s_b[17], s_b};
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      left_drive <= drive_enable ? to_motor(left_sum) : 16'd0;
      right_drive <= drive_enable ? to_motor(right_sum) : 16'd0;
    end
  end

endmodule

// File: rtl/drive_joystick_mixer_core.sv
// top level of the drive joystick mixer: config registers, pipeline control
// The mixer takes one stick sample per cycle while the output is not stalled and
// returns one motor pair per sample through a five-stage pipeline: magnitude and
// pot product, curve square and sine index, shaped value and precision gain, gain
// multiply, then mixing and saturation into the output register. Each multiplier
// has a stage of its own, which sets the depth; throughput is one transaction per
// cycle when the output is not stalled, and a stall at the output holds only as
// many stages as are full.
`timescale 1ns / 1ps

module drive_joystick_mixer_core
  import djm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // stick_a_y [15:0], stick_a_x [31:16], stick_b_y [47:32], pot_level [63:48]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_drive [15:0], right_drive [31:16]
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "drive_joystick_mixer_core_macros.svh"

  logic       mix_mode;
  logic [2:0] curve_select;
  logic       precision_on;
  logic       drive_enable;

  logic [4:0] vld;
  logic [4:0] en;
  adv_t       adv;
  logic       s_acc;
  logic       m_acc;
  logic       cfg_wr;

  logic [15:0] axis_b;
  logic [16:0] mag_a;
  logic        neg_a;
  logic [16:0] mag_b;
  logic        neg_b;
  logic [16:0] gain;
  logic [15:0] left_drive;
  logic [15:0] right_drive;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode <= 1'b0;
      curve_select <= 3'd0;
      precision_on <= 1'b0;
      drive_enable <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_MIX_MODE:     mix_mode <= pwdata[0];
        REG_CURVE_SELECT: curve_select <= pwdata[2:0];
        REG_PRECISION_ON: precision_on <= pwdata[0];
        REG_DRIVE_ENABLE: drive_enable <= pwdata[0];
        default:          mix_mode <= mix_mode;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_MIX_MODE:     prdata = {31'd0, mix_mode};
      REG_CURVE_SELECT: prdata = {29'd0, curve_select};
      REG_PRECISION_ON: prdata = {31'd0, precision_on};
      REG_DRIVE_ENABLE: prdata = {31'd0, drive_enable};
      default:          prdata = 32'd0;
    endcase
  end

  // pipeline valid chain, each stage moves when the next one can take it
  always_comb begin
    en[4] = !vld[4] || m_axis_tready;
    en[3] = !vld[3] || en[4];
    en[2] = !vld[2] || en[3];
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
    adv = '{s1: en[0], s2: en[1], s3: en[2], s4: en[3], s5: en[4]};
  end

  assign s_axis_tready = en[0] && !rst;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = vld[4];
  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 5'd0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
    end
  end

  // second axis: right stick in tank mode, turn axis in differential mode
  assign axis_b = mix_mode ? s_axis_tdata[31:16] : s_axis_tdata[47:32];

  djm_curve u_curve_a (
    .clk          (clk),
    .adv          (adv),
    .curve_select (curve_select),
    .raw          (s_axis_tdata[15:0]),
    .shaped_mag   (mag_a),
    .shaped_neg   (neg_a)
  );

  djm_curve u_curve_b (
    .clk          (clk),
    .adv          (adv),
    .curve_select (curve_select),
    .raw          (axis_b),
    .shaped_mag   (mag_b),
    .shaped_neg   (neg_b)
  );

  djm_gain u_gain (
    .clk          (clk),
    .adv          (adv),
    .precision_on (precision_on),
    .pot_level    (s_axis_tdata[63:48]),
    .gain         (gain)
  );

  djm_mix u_mix (
    .clk          (clk),
    .adv          (adv),
    .mix_mode     (mix_mode),
    .drive_enable (drive_enable),
    .mag_a        (mag_a),
    .neg_a        (neg_a),
    .mag_b        (mag_b),
    .neg_b        (neg_b),
    .gain         (gain),
    .left_drive   (left_drive),
    .right_drive  (right_drive)
  );

  assign m_axis_tdata = {right_drive, left_drive};

  `DJM_ASSERT_NEXT(a_fill_up, s_acc && !m_acc, $countones(vld) == $past($countones(vld)) + 1)
  `DJM_ASSERT_NEXT(a_drain, !s_acc && m_acc, $countones(vld) + 1 == $past($countones(vld)))
  `DJM_ASSERT_NEXT(a_steady, s_acc == m_acc, $countones(vld) == $past($countones(vld)))
  `DJM_ASSERT_HOLDS(a_no_min_code, m_axis_tvalid, left_drive != 16'h8000 && right_drive != 16'h8000)

endmodule

// File: sim/tb_drive_joystick_mixer_core.sv
// testbench for the drive joystick mixer core: stick samples in, motor pairs checked
`timescale 1ns / 1ps

module tb_drive_joystick_mixer_core;
  import djm_pkg::*;

  localparam int SINE_ENTRIES = 256;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [2:0] CURVE_SPARE_6 = 3'd6;
  localparam logic [2:0] CURVE_SPARE_7 = 3'd7;
  localparam int PIPE_SETTLE = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CHUNKS = 12;
  localparam int CHUNK_ITEMS = 100;
  localparam int DIRECTED_COUNT = 21;

  typedef struct packed {
    logic        mix;
    logic [2:0]  curve;
    logic        prec;
    logic        drv;
    logic [15:0] ay;
    logic [15:0] ax;
    logic [15:0] by;
    logic [15:0] pot;
    logic        typed;
    logic [15:0] left;
    logic [15:0] right;
  } stim_row_t;

  // mix, curve, precision, drive, a_y, a_x, b_y, pot, typed, left, right
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{1'b0, CURVE_NONE, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      1'b1, 16'h0000, 16'h0000},
    '{1'b0, CURVE_NONE, 1'b0, 1'b1, 16'h7FFF, 16'h1234, 16'h8000, 16'hFFFF,
      1'b1, 16'h7FFE, 16'h8001},
    '{1'b0, CURVE_NONE, 1'b0, 1'b1, 16'h8001, 16'h7FFF, 16'h0001, 16'h8000,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_LINEAR, 1'b0, 1'b1, 16'h0020, 16'h0000, 16'hFFE0, 16'hFFFF,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_LINEAR, 1'b0, 1'b1, 16'h0021, 16'h0000, 16'hFFDF, 16'h0000,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_EASE_IN, 1'b0, 1'b1, 16'h4000, 16'h0000, 16'h8000, 16'hFFFF,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_EASE_IN, 1'b0, 1'b1, 16'hC000, 16'h0000, 16'h7FFF, 16'h1234,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_EASE_OUT, 1'b0, 1'b1, 16'h0021, 16'h0000, 16'h8001, 16'hFFFF,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_EASE_IN_OUT, 1'b0, 1'b1, 16'h3FFF, 16'h0000, 16'h4000, 16'hFFFF,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_EASE_IN_OUT, 1'b0, 1'b1, 16'hC001, 16'h0000, 16'h8000, 16'h0000,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_SINE, 1'b0, 1'b1, 16'h7FFF, 16'h0000, 16'h8001, 16'hFFFF,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_SINE, 1'b0, 1'b1, 16'h0080, 16'h0000, 16'hFF00, 16'h8000,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_SPARE_6, 1'b0, 1'b1, 16'h5555, 16'h0000, 16'hAAAA, 16'hFFFF,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_SPARE_7, 1'b0, 1'b1, 16'h2000, 16'h0000, 16'hE000, 16'hFFFF,
      1'b0, 16'h0000, 16'h0000},
    '{1'b1, CURVE_NONE, 1'b0, 1'b1, 16'h7FFF, 16'h7FFF, 16'h1111, 16'hFFFF,
      1'b0, 16'h0000, 16'h0000},
    '{1'b1, CURVE_NONE, 1'b0, 1'b1, 16'h8000, 16'h7FFF, 16'h2222, 16'hFFFF,
      1'b0, 16'h0000, 16'h0000},
    '{1'b1, CURVE_EASE_IN, 1'b0, 1'b1, 16'h4000, 16'hC000, 16'h0000, 16'h8000,
      1'b0, 16'h0000, 16'h0000},
    '{1'b1, CURVE_SINE, 1'b1, 1'b1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_LINEAR, 1'b1, 1'b1, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000,
      1'b0, 16'h0000, 16'h0000},
    '{1'b0, CURVE_NONE, 1'b0, 1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF,
      1'b1, 16'h0000, 16'h0000},
    '{1'b1, CURVE_SINE, 1'b0, 1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
      1'b1, 16'h0000, 16'h0000}
  };

  localparam logic [15:0] AXIS_CORNERS [8] = '{
    16'h8000, 16'h7FFF, 16'h0000, 16'h0020, 16'hFFE0, 16'h0021, 16'h4000, 16'h3FFF
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        typed_use = 1'b0;
  logic [31:0] typed_pair = '0;

  logic        cfg_mix = 1'b0;
  logic [2:0]  cfg_curve = CURVE_NONE;
  logic        cfg_prec = 1'b0;
  logic        cfg_drive = 1'b1;

  int          sine_q15 [0:SINE_ENTRIES];
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  logic [31:0] pairs_due [$];

  drive_joystick_mixer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  function automatic int sine_entry(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] r;
    x = (64'(k) * QUARTER_TURN_Q30) / 64'(SINE_ENTRIES);
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    r = (acc + 64'd16384) >> 15;
    return (r > 64'd32768) ? 32768 : int'(r);
  endfunction

  function automatic int curve_magnitude(int m, logic [2:0] curve);
    int u;
    u = 32768 - m;
    case (curve)
      CURVE_LINEAR: return m;
      CURVE_EASE_IN: return (m * m + 16384) >> 15;
      CURVE_EASE_OUT: return 32768 - ((u * u + 16384) >> 15);
      CURVE_EASE_IN_OUT: begin
        if (m < 16384) return (m * m + 8192) >> 14;
        return 32768 - ((u * u + 8192) >> 14);
      end
      default: return sine_q15[(m * SINE_ENTRIES + 16384) >> 15];
    endcase
  endfunction

  function automatic int shape_axis(logic [15:0] raw);
    int v;
    int m;
    int e;
    v = int'($signed(raw));
    m = (v < 0) ? -v : v;
    if (cfg_curve == CURVE_NONE || m <= 32) return v;
    e = (m >= 32768) ? 32768 : curve_magnitude(m, cfg_curve);
    return (v < 0) ? -e : e;
  endfunction

  function automatic int scale_by_gain(int v, longint g);
    longint m;
    longint r;
    m = (v < 0) ? -v : v;
    r = (m * g + 32768) >> 16;
    return (v < 0) ? -int'(r) : int'(r);
  endfunction

  function automatic logic [15:0] motor_cmd(int v);
    longint m;
    longint r;
    m = (v < 0) ? -v : v;
    if (m > 32768) m = 32768;
    r = (m * 32767) >> 15;
    return (v < 0) ? 16'(-r) : 16'(r);
  endfunction

  function automatic logic [31:0] mix_motor_pair(logic [63:0] stick_word);
    longint g;
    int left;
    int right;
    int thr;
    int trn;
    if (!cfg_drive) return '0;
    g = 22938 + ((42598 * longint'(stick_word[63:48]) + 32768) >> 16);
    if (cfg_prec) g = (g * 26214 + 32768) >> 16;
    if (!cfg_mix) begin
      left = scale_by_gain(shape_axis(stick_word[15:0]), g);
      right = scale_by_gain(shape_axis(stick_word[47:32]), g);
    end else begin
      thr = scale_by_gain(shape_axis(stick_word[15:0]), g);
      trn = scale_by_gain(shape_axis(stick_word[31:16]), g);
      left = thr + trn;
      right = thr - trn;
    end
    return {motor_cmd(right), motor_cmd(left)};
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(9))
      0: return AXIS_CORNERS[$urandom_range(7)];
      1: return 16'(int'($urandom_range(80)) - 40);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_pot();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_sample(logic [63:0] stick_word, logic use_typed, logic [31:0] pair);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= stick_word;
    typed_use <= use_typed;
    typed_pair <= pair;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      note_mismatch($sformatf("register %s read %0h, wrote %0h", idx.name(), prdata, value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(logic mix, logic [2:0] curve, logic prec, logic drv);
    settle();
    reg_write(REG_MIX_MODE, 32'(mix));
    reg_write(REG_CURVE_SELECT, 32'(curve));
    reg_write(REG_PRECISION_ON, 32'(prec));
    reg_write(REG_DRIVE_ENABLE, 32'(drv));
    cfg_mix = mix;
    cfg_curve = curve;
    cfg_prec = prec;
    cfg_drive = drv;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    logic [31:0] due;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pairs_due.push_back(typed_use ? typed_pair : mix_motor_pair(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pairs_due.size() == 0) begin
          note_mismatch($sformatf("motor pair %0h with no transaction pending", m_axis_tdata));
        end else begin
          due = pairs_due.pop_front();
          if (m_axis_tdata[15:0] !== due[15:0]) begin
            note_mismatch($sformatf("left_drive got %0d expected %0d",
                                    $signed(m_axis_tdata[15:0]), $signed(due[15:0])));
          end
          if (m_axis_tdata[31:16] !== due[31:16]) begin
            note_mismatch($sformatf("right_drive got %0d expected %0d",
                                    $signed(m_axis_tdata[31:16]), $signed(due[31:16])));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("drive_joystick_mixer_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    int chunk;
    int i;
    for (int k = 0; k <= SINE_ENTRIES; k++) sine_q15[k] = sine_entry(k);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.mix != cfg_mix || row.curve != cfg_curve || row.prec != cfg_prec ||
          row.drv != cfg_drive) begin
        apply_config(row.mix, row.curve, row.prec, row.drv);
      end
      send_sample({row.pot, row.by, row.ax, row.ay}, row.typed, {row.right, row.left});
    end

    for (chunk = 0; chunk < CHUNKS; chunk++) begin
      apply_config(1'(chunk % 2), 3'((chunk * 3) % 8), 1'((chunk / 3) % 2), chunk != 10);
      case (chunk % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 59;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 59;
        end
        default: begin
          src_idle_pct = 15;
          sink_stall_pct = 15;
        end
      endcase
      for (i = 0; i < CHUNK_ITEMS; i++) begin
        send_sample({rand_pot(), rand_axis(), rand_axis(), rand_axis()}, 1'b0, '0);
      end
    end

    settle();
    if (mismatch_count == 0 && pairs_due.size() == 0) begin
      $display("drive_joystick_mixer_core regression: pass");
    end else begin
      $display("drive_joystick_mixer_core regression: fail");
    end
    $finish;
  end

endmodule
